// File: rtl/core/sptt_pkg.sv
// shared types and codes for the sparse triplet store with transposed dump
`default_nettype none

package sptt_pkg;

    // width of the result status field
    localparam int STATUS_BITS = 3;

    // item kind codes
    localparam logic KIND_SET  = 1'b0;
    localparam logic KIND_DUMP = 1'b1;

    // result status codes
    typedef enum logic [STATUS_BITS-1:0] {
        ST_UPDATED  = 3'd0,
        ST_APPENDED = 3'd1,
        ST_DROPPED  = 3'd2,
        ST_ENTRY    = 3'd3,
        ST_EMPTY    = 3'd4
    } t_status;

    // sequencer states, one-hot
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_RESP = 4'b0100,
        S_DUMP = 4'b1000
    } t_state;

endpackage

`default_nettype wire

// File: rtl/core/sparse_triplet_store_transpose_top.sv
// sparse matrix triplet store with search, update, append and transposed dump
`default_nettype none

// Holds up to TABLE_DEPTH (row, column, value) triplets in insertion order in a
// single-port-write, registered-read memory. A set transaction walks the stored
// triplets one per cycle through a single key comparator. It overwrites the value
// of the matching triplet (updated), appends a new one (appended) or, with the
// table full and no match, leaves the table alone (dropped). Its result is
// registered from the response state once the output register is free, and the
// sequencer then returns to idle to take the next transaction. A dump transaction
// emits each stored triplet with row and column swapped, one per cycle while the
// output is not stalled, last set on the final one. An empty table gives a single
// empty-status result. The walk over the memory, together with any output stalls,
// sets the item time. The block takes one item at a time: o_stall is low only
// while the sequencer is idle. The output register lets a new item be accepted
// while the previous result still waits.
module sparse_triplet_store_transpose_top #(
    parameter int TABLE_DEPTH = 64,
    parameter int INDEX_BITS  = 10,
    parameter int VALUE_BITS  = 32
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // input channel
    input  wire logic                               i_valid,
    output logic                                    o_stall,
    input  wire logic                               i_kind,
    input  wire logic [INDEX_BITS-1:0]              i_row_index,
    input  wire logic [INDEX_BITS-1:0]              i_col_index,
    input  wire logic signed [VALUE_BITS-1:0]       i_new_value,
    // output channel
    output logic                                    o_valid,
    input  wire logic                               i_stall,
    output logic [sptt_pkg::STATUS_BITS-1:0]        o_status,
    output logic [INDEX_BITS-1:0]                   o_out_row,
    output logic [INDEX_BITS-1:0]                   o_out_col,
    output logic signed [VALUE_BITS-1:0]            o_out_value,
    output logic                                    o_last
);

    import sptt_pkg::*;

    localparam int CNT_BITS  = $clog2(TABLE_DEPTH + 1);
    localparam int ADDR_BITS = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    typedef struct packed {
        logic [INDEX_BITS-1:0] row;
        logic [INDEX_BITS-1:0] col;
        logic [VALUE_BITS-1:0] value;
    } t_entry;

    // triplet memory
    t_entry mem [TABLE_DEPTH];

    t_state                r_state, n_state;
    logic [CNT_BITS-1:0]   r_count, n_count;
    logic [CNT_BITS-1:0]   r_ptr, n_ptr;
    t_entry                r_rd_data;

    // captured transaction
    t_entry                r_key, n_key;
    t_status               r_resp, n_resp;

    // output register
    logic                  r_out_valid, n_out_valid;
    t_status               r_out_status, n_out_status;
    logic [INDEX_BITS-1:0] r_out_row, n_out_row;
    logic [INDEX_BITS-1:0] r_out_col, n_out_col;
    logic [VALUE_BITS-1:0] r_out_value, n_out_value;
    logic                  r_out_last, n_out_last;

    logic                  w_in_acc;
    logic                  w_out_free;
    logic                  w_match;
    logic                  w_wr_en;
    logic [ADDR_BITS-1:0]  w_wr_addr;
    logic                  w_at_end;
    logic                  w_last_entry;

    assign o_stall     = (r_state != S_IDLE);
    assign w_in_acc    = i_valid && (r_state == S_IDLE);
    assign w_out_free  = !r_out_valid || !i_stall;

    // the shared key comparator
    assign w_match      = (r_rd_data.row == r_key.row) && (r_rd_data.col == r_key.col);
    assign w_at_end     = (r_ptr == r_count);
    assign w_last_entry = ((r_ptr + CNT_BITS'(1)) == r_count);

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_ptr        = r_ptr;
        n_key        = r_key;
        n_resp       = r_resp;
        n_out_valid  = r_out_valid && i_stall;
        n_out_status = r_out_status;
        n_out_row    = r_out_row;
        n_out_col    = r_out_col;
        n_out_value  = r_out_value;
        n_out_last   = r_out_last;
        w_wr_en      = 1'b0;
        w_wr_addr    = r_ptr[ADDR_BITS-1:0];

        case (r_state)
            S_IDLE: begin
                n_ptr = '0;
                if (w_in_acc) begin
                    n_key.row = i_row_index;
                    n_key.col = i_col_index;
                    n_key.value = i_new_value;
                    if (i_kind == KIND_SET) begin
                        n_state = S_SCAN;
                    end else if (r_count == '0) begin
                        n_resp  = ST_EMPTY;
                        n_state = S_RESP;
                    end else begin
                        n_state = S_DUMP;
                    end
                end
            end
            S_SCAN: begin
                if (w_at_end) begin
                    // no match among stored triplets
                    if (r_count == CNT_BITS'(TABLE_DEPTH)) begin
                        n_resp = ST_DROPPED;
                    end else begin
                        w_wr_en = 1'b1;
                        n_count = r_count + CNT_BITS'(1);
                        n_resp  = ST_APPENDED;
                    end
                    n_state = S_RESP;
                end else if (w_match) begin
                    w_wr_en = 1'b1;
                    n_resp  = ST_UPDATED;
                    n_state = S_RESP;
                end else begin
                    n_ptr = r_ptr + CNT_BITS'(1);
                end
            end
            S_RESP: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_resp;
                    n_out_row    = '0;
                    n_out_col    = '0;
                    n_out_value  = '0;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_DUMP: begin
                if (w_out_free) begin
                    // swap row and column on the way out
                    n_out_valid  = 1'b1;
                    n_out_status = ST_ENTRY;
                    n_out_row    = r_rd_data.col;
                    n_out_col    = r_rd_data.row;
                    n_out_value  = r_rd_data.value;
                    n_out_last   = w_last_entry;
                    n_ptr        = r_ptr + CNT_BITS'(1);
                    if (w_last_entry) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // memory write and registered read, read address follows the next pointer
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[w_wr_addr] <= r_key;
        end
        r_rd_data <= mem[n_ptr[ADDR_BITS-1:0]];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_ptr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ptr       <= n_ptr;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_key        <= n_key;
        r_resp       <= n_resp;
        r_out_status <= n_out_status;
        r_out_row    <= n_out_row;
        r_out_col    <= n_out_col;
        r_out_value  <= n_out_value;
        r_out_last   <= n_out_last;
    end

    assign o_valid     = r_out_valid;
    assign o_status    = r_out_status;
    assign o_out_row   = r_out_row;
    assign o_out_col   = r_out_col;
    assign o_out_value = r_out_value;
    assign o_last      = r_out_last;

endmodule

`default_nettype wire

// File: dv/sparse_triplet_store_transpose_top_test.sv
// self-checking testbench for the sparse triplet store with transposed dump
`default_nettype none

module sparse_triplet_store_transpose_top_test;

    localparam int DEPTH        = 64;
    localparam int IDX          = 10;
    localparam int VAL          = 32;
    localparam int RANDOM_ITEMS = 200;
    localparam int PHASE_ITEMS  = 40;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 100;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int PRINT_CAP    = 40;

    // one expected result of the block
    typedef struct packed {
        sptt_pkg::t_status       status;
        logic [IDX-1:0]          row;
        logic [IDX-1:0]          col;
        logic signed [VAL-1:0]   value;
        logic                    last;
    } t_transposed_result;

    // shadow of the triplet table and the queue of results still owed
    class triplet_scoreboard;
        logic [IDX-1:0]        stored_row[DEPTH];
        logic [IDX-1:0]        stored_col[DEPTH];
        logic signed [VAL-1:0] stored_value[DEPTH];
        int unsigned           stored_count;
        t_transposed_result    expected_results[$];
        int unsigned           errors;

        function new();
            stored_count = 0;
            errors = 0;
        endfunction

        task report(input string msg);
            if (errors < PRINT_CAP)
                $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        // append one owed result at the tail of the queue
        function void owe_result(input t_transposed_result res);
            expected_results.insert(expected_results.size(), res);
        endfunction

        // work out the results of one accepted transaction and update the table
        function void note_item(input logic kind, input logic [IDX-1:0] row,
                                input logic [IDX-1:0] col,
                                input logic signed [VAL-1:0] value);
            t_transposed_result res;
            bit                 hit;
            hit = 0;
            res = '0;
            res.last = 1'b1;
            if (kind == sptt_pkg::KIND_SET) begin
                for (int i = 0; i < stored_count; i++) begin
                    if (!hit && stored_row[i] == row && stored_col[i] == col) begin
                        stored_value[i] = value;
                        hit = 1;
                    end
                end
                if (hit) begin
                    res.status = sptt_pkg::ST_UPDATED;
                end else if (stored_count >= DEPTH) begin
                    res.status = sptt_pkg::ST_DROPPED;
                end else begin
                    stored_row[stored_count]   = row;
                    stored_col[stored_count]   = col;
                    stored_value[stored_count] = value;
                    stored_count++;
                    res.status = sptt_pkg::ST_APPENDED;
                end
                owe_result(res);
            end else if (stored_count == 0) begin
                res.status = sptt_pkg::ST_EMPTY;
                owe_result(res);
            end else begin
                // transpose: row and column swap places
                for (int i = 0; i < stored_count; i++) begin
                    res.status = sptt_pkg::ST_ENTRY;
                    res.row    = stored_col[i];
                    res.col    = stored_row[i];
                    res.value  = stored_value[i];
                    res.last   = (i + 1 == stored_count);
                    owe_result(res);
                end
            end
        endfunction

        // compare one accepted result with the oldest one owed
        task check_result(input logic [sptt_pkg::STATUS_BITS-1:0] status,
                          input logic [IDX-1:0] row, input logic [IDX-1:0] col,
                          input logic signed [VAL-1:0] value, input logic last);
            t_transposed_result want;
            if (expected_results.size() == 0) begin
                report($sformatf("result with none owed: status %0d row %0d col %0d",
                                 status, row, col));
                return;
            end
            want = expected_results.pop_front();
            if (status !== want.status)
                report($sformatf("status %0d, expected %0d", status, want.status));
            if (row !== want.row)
                report($sformatf("out_row %0d, expected %0d", row, want.row));
            if (col !== want.col)
                report($sformatf("out_col %0d, expected %0d", col, want.col));
            if (value !== want.value)
                report($sformatf("out_value %0d, expected %0d", value, want.value));
            if (last !== want.last)
                report($sformatf("last %0b, expected %0b", last, want.last));
        endtask
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic                  i_kind = sptt_pkg::KIND_SET;
    logic [IDX-1:0]        i_row_index = '0;
    logic [IDX-1:0]        i_col_index = '0;
    logic signed [VAL-1:0] i_new_value = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [sptt_pkg::STATUS_BITS-1:0] o_status;
    logic [IDX-1:0]        o_out_row;
    logic [IDX-1:0]        o_out_col;
    logic signed [VAL-1:0] o_out_value;
    logic                  o_last;

    triplet_scoreboard board = new();
    int unsigned       send_idle_pct = 0;
    int unsigned       stall_pct = 0;
    logic              hold_off = 1'b0;
    int unsigned       cycle_count = 0;

    sparse_triplet_store_transpose_top #(
        .TABLE_DEPTH (DEPTH),
        .INDEX_BITS  (IDX),
        .VALUE_BITS  (VAL)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_kind      (i_kind),
        .i_row_index (i_row_index),
        .i_col_index (i_col_index),
        .i_new_value (i_new_value),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_status    (o_status),
        .o_out_row   (o_out_row),
        .o_out_col   (o_out_col),
        .o_out_value (o_out_value),
        .o_last      (o_last)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // receiver stall, random or held off for a long stretch
    always @(posedge i_clk) begin
        i_stall <= hold_off || ($urandom_range(99) < stall_pct);
    end

    // output monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0)
            board.check_result(o_status, o_out_row, o_out_col, o_out_value, o_last);
    end

    // run time limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("sparse_triplet_store_transpose_top_test failed");
            $finish;
        end
    end

    // offer one transaction, with random idle cycles first, and wait for it to go in
    task automatic send_item(input logic kind, input logic [IDX-1:0] row,
                             input logic [IDX-1:0] col,
                             input logic signed [VAL-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_kind      <= kind;
        i_row_index <= row;
        i_col_index <= col;
        i_new_value <= value;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        board.note_item(kind, row, col, value);
    endtask

    // keep the receiver stalled for a counted number of cycles
    task automatic hold_receiver(input int unsigned cycles);
        hold_off <= 1'b1;
        repeat (cycles) @(posedge i_clk);
        hold_off <= 1'b0;
    endtask

    // value with a bias towards the extremes
    function automatic logic signed [VAL-1:0] pick_value();
        case ($urandom_range(7))
            0: pick_value = {1'b1, {(VAL-1){1'b0}}};
            1: pick_value = {1'b0, {(VAL-1){1'b1}}};
            2: pick_value = '0;
            3: pick_value = '1;
            default: pick_value = $urandom();
        endcase
    endfunction

    // stimulus
    initial begin
        int unsigned    pick;
        int unsigned    idx;
        int unsigned    phase;
        logic [IDX-1:0] any_row;
        logic [IDX-1:0] any_col;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty dump, corner keys and values, updates, dumps
        send_item(sptt_pkg::KIND_DUMP, '0, '0, '0);
        send_item(sptt_pkg::KIND_SET, '0, '0, {1'b1, {(VAL-1){1'b0}}});
        send_item(sptt_pkg::KIND_SET, '1, '1, {1'b0, {(VAL-1){1'b1}}});
        send_item(sptt_pkg::KIND_SET, '0, '1, '1);
        send_item(sptt_pkg::KIND_SET, '1, '0, '0);
        send_item(sptt_pkg::KIND_DUMP, '1, '1, '1);
        send_item(sptt_pkg::KIND_SET, '0, '0, 32'sd12345);
        send_item(sptt_pkg::KIND_SET, 10'h2aa, 10'h155, 32'haaaaaaaa);
        send_item(sptt_pkg::KIND_SET, 10'h155, 10'h2aa, 32'h55555555);
        send_item(sptt_pkg::KIND_SET, 10'h2aa, 10'h155, 32'h5555aaaa);
        send_item(sptt_pkg::KIND_SET, '1, '0, -32'sd7);
        send_item(sptt_pkg::KIND_DUMP, 10'h2aa, 10'h155, 32'haaaaaaaa);

        // random: updates of stored keys, fresh keys that fill the table, dumps
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % PHASE_ITEMS == 0) begin
                phase = n / PHASE_ITEMS;
                case (phase)
                    0: begin send_idle_pct = 0;  stall_pct <= 0;  end
                    1: begin send_idle_pct = 80; stall_pct <= 0;  end
                    2: begin send_idle_pct = 0;  stall_pct <= 80; end
                    3: begin send_idle_pct = 25; stall_pct <= 25; end
                    default: begin
                        send_idle_pct = 0;
                        stall_pct <= 0;
                        fork
                            hold_receiver(HOLD_CYCLES);
                        join_none
                    end
                endcase
            end
            pick    = $urandom_range(99);
            any_row = IDX'($urandom_range(2**IDX - 1));
            any_col = IDX'($urandom_range(2**IDX - 1));
            if (pick < 14 || (phase >= 4 && n % PHASE_ITEMS == 0)) begin
                send_item(sptt_pkg::KIND_DUMP, any_row, any_col, pick_value());
            end else if (pick < 50 && board.stored_count != 0) begin
                idx = $urandom_range(board.stored_count - 1);
                send_item(sptt_pkg::KIND_SET, board.stored_row[idx],
                          board.stored_col[idx], pick_value());
            end else if (pick < 60) begin
                // clustered keys so that appends and updates collide
                send_item(sptt_pkg::KIND_SET, IDX'($urandom_range(3)),
                          IDX'($urandom_range(3)), pick_value());
            end else begin
                send_item(sptt_pkg::KIND_SET, any_row, any_col, pick_value());
            end
        end

        // drain
        i_valid   <= 1'b0;
        stall_pct <= 0;
        while (board.expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (board.errors == 0)
            $display("sparse_triplet_store_transpose_top_test passed");
        else
            $display("sparse_triplet_store_transpose_top_test failed");
        $finish;
    end

endmodule

`default_nettype wire
